// ===== src/svau_pkg.sv =====
// Shared widths and operation codes of the scroll and video-memory address unit.
`timescale 1ns / 1ps
`default_nettype none

package svau_pkg;

   localparam int ADDR_W   = 15;
   localparam int FUNC_W   = 4;
   localparam int VALUE_W  = 8;
   localparam int FINE_X_W = 3;
   localparam int COARSE_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_CTRL_WRITE   = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SCROLL_WRITE = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADDR_WRITE   = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_DATA_WRITE   = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_STATUS_READ  = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_DATA_READ    = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_INC_X        = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_INC_Y        = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_COPY_HORIZ   = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_COPY_VERT    = 4'd9;

   localparam logic [COARSE_W-1:0] ROW_WRAP_FLIP = 5'd29;
   localparam logic [COARSE_W-1:0] ROW_LAST      = 5'd31;

endpackage

`default_nettype wire

// ===== src/svau_req_if.sv =====
// Request channel carrying one operation item into the address unit.
`timescale 1ns / 1ps
`default_nettype none

interface svau_req_if import svau_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [VALUE_W-1:0]  value;
   logic                rendering;

   modport source (output valid, output func, output value, output rendering, input ready);
   modport sink   (input valid, input func, input value, input rendering, output ready);
endinterface

`default_nettype wire

// ===== src/svau_rsp_if.sv =====
// Response channel carrying one address result item out of the address unit.
`timescale 1ns / 1ps
`default_nettype none

interface svau_rsp_if import svau_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_W-1:0]    bus_address;
   logic [ADDR_W-1:0]    vram_address;
   logic [FINE_X_W-1:0]  fine_x;
   logic                 write_toggle;

   modport source (output valid, output bus_address, output vram_address, output fine_x,
                   output write_toggle, input ready);
   modport sink   (input valid, input bus_address, input vram_address, input fine_x,
                   input write_toggle, output ready);
endinterface

`default_nettype wire

// ===== src/scroll_vram_address_unit.sv =====
// Top level of the scroll and video-memory address unit.
//
//   channel    direction  handshake      payload
//   req_chan   in         valid/ready    func, value, rendering
//   rsp_chan   out        valid/ready    bus_address, vram_address, fine_x, write_toggle
//
// Each item is worked out from the state registers and the request fields; its result
// sits in the output register on the next cycle, one item per cycle unless stalled.
// The state registers are updated at the edge where the item is accepted.
// A request is taken while the output register is empty or being drained in that cycle.
// Synchronous reset clears the address state, fine X, toggle, step flag and output valid.
`timescale 1ns / 1ps
`default_nettype none

module scroll_vram_address_unit import svau_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   svau_req_if.sink     req_chan,
   svau_rsp_if.source   rsp_chan
);

   logic [ADDR_W-1:0]   cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]   tmp_addr_ff, tmp_addr_in;
   logic [FINE_X_W-1:0] fine_x_ff, fine_x_in;
   logic                toggle_ff, toggle_in;
   logic                by_row_ff, by_row_in;

   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_bus_ff;
   logic [ADDR_W-1:0]   rsp_vram_ff;
   logic [FINE_X_W-1:0] rsp_fine_x_ff;
   logic                rsp_toggle_ff;

   logic                accept;
   logic [ADDR_W-1:0]   step_addr;

   function automatic logic [ADDR_W-1:0] inc_coarse_x(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a[4:0] == 5'h1f) begin
         r = {a[14:11], ~a[10], a[9:5], 5'd0};
      end else begin
         r = a + ADDR_W'(1);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] inc_y(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a[14:12] == 3'd7) begin
         if (a[9:5] == ROW_WRAP_FLIP) begin
            r = {3'd0, ~a[11], a[10], 5'd0, a[4:0]};
         end else if (a[9:5] == ROW_LAST) begin
            r = {3'd0, a[11:10], 5'd0, a[4:0]};
         end else begin
            r = {3'd0, a[11:10], a[9:5] + 5'd1, a[4:0]};
         end
      end else begin
         r = {a[14:12] + 3'd1, a[11:0]};
      end
      return r;
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign step_addr      = cur_addr_ff + (by_row_ff ? ADDR_W'(32) : ADDR_W'(1));

   always_comb begin
      cur_addr_in = cur_addr_ff;
      tmp_addr_in = tmp_addr_ff;
      fine_x_in   = fine_x_ff;
      toggle_in   = toggle_ff;
      by_row_in   = by_row_ff;
      unique case (req_chan.func)
         FUNC_CTRL_WRITE: begin
            tmp_addr_in = {tmp_addr_ff[14:12], req_chan.value[1:0], tmp_addr_ff[9:0]};
            by_row_in   = req_chan.value[2];
         end
         FUNC_SCROLL_WRITE: begin
            if (!toggle_ff) begin
               tmp_addr_in = {tmp_addr_ff[14:5], req_chan.value[7:3]};
               fine_x_in   = req_chan.value[2:0];
            end else begin
               tmp_addr_in = {req_chan.value[2:0], tmp_addr_ff[11:10], req_chan.value[7:3],
                              tmp_addr_ff[4:0]};
            end
            toggle_in = !toggle_ff;
         end
         FUNC_ADDR_WRITE: begin
            if (!toggle_ff) begin
               tmp_addr_in = {1'b0, req_chan.value[5:0], tmp_addr_ff[7:0]};
            end else begin
               tmp_addr_in = {tmp_addr_ff[14:8], req_chan.value};
               cur_addr_in = {tmp_addr_ff[14:8], req_chan.value};
            end
            toggle_in = !toggle_ff;
         end
         FUNC_DATA_WRITE: begin
            if (req_chan.rendering) begin
               cur_addr_in = inc_y(inc_coarse_x(cur_addr_ff));
            end else begin
               cur_addr_in = step_addr;
            end
         end
         FUNC_STATUS_READ: begin
            toggle_in = 1'b0;
         end
         FUNC_DATA_READ: begin
            cur_addr_in = step_addr;
         end
         FUNC_INC_X: begin
            cur_addr_in = inc_coarse_x(cur_addr_ff);
         end
         FUNC_INC_Y: begin
            cur_addr_in = inc_y(cur_addr_ff);
         end
         FUNC_COPY_HORIZ: begin
            cur_addr_in = {cur_addr_ff[14:11], tmp_addr_ff[10], cur_addr_ff[9:5],
                           tmp_addr_ff[4:0]};
         end
         FUNC_COPY_VERT: begin
            cur_addr_in = {tmp_addr_ff[14:11], cur_addr_ff[10], tmp_addr_ff[9:5],
                           cur_addr_ff[4:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff  <= '0;
         tmp_addr_ff  <= '0;
         fine_x_ff    <= '0;
         toggle_ff    <= 1'b0;
         by_row_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cur_addr_ff <= cur_addr_in;
            tmp_addr_ff <= tmp_addr_in;
            fine_x_ff   <= fine_x_in;
            toggle_ff   <= toggle_in;
            by_row_ff   <= by_row_in;
         end
         if (req_chan.ready) begin
            rsp_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_bus_ff    <= cur_addr_ff;
         rsp_vram_ff   <= cur_addr_in;
         rsp_fine_x_ff <= fine_x_in;
         rsp_toggle_ff <= toggle_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.bus_address  = rsp_bus_ff;
   assign rsp_chan.vram_address = rsp_vram_ff;
   assign rsp_chan.fine_x       = rsp_fine_x_ff;
   assign rsp_chan.write_toggle = rsp_toggle_ff;

endmodule

`default_nettype wire

// ===== src/svau_checker.sv =====
// Port-level checker for the scroll and video-memory address unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module svau_checker import svau_pkg::*; (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_ready,
   input wire [FUNC_W-1:0]   req_func,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire [ADDR_W-1:0]   rsp_bus_address,
   input wire [ADDR_W-1:0]   rsp_vram_address,
   input wire                rsp_write_toggle
);

   logic              seen_ff;
   logic [ADDR_W-1:0] last_vram_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_vram_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff      <= 1'b1;
         last_vram_ff <= rsp_vram_address;
      end
   end

   // A stalled result item stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Every accepted request yields a result item on the next cycle.
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request produced no result item");

   // Each result starts from the address the previous result ended on.
   a_addr_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && seen_ff) |-> (rsp_bus_address == last_vram_ff))
      else $error("address chain broken between result items");

   // A status read always leaves the write toggle cleared.
   a_status_clear: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_STATUS_READ) |=> !rsp_write_toggle)
      else $error("status read did not clear the write toggle");

endmodule

bind scroll_vram_address_unit svau_checker u_svau_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_func         (req_chan.func),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_bus_address  (rsp_chan.bus_address),
   .rsp_vram_address (rsp_chan.vram_address),
   .rsp_write_toggle (rsp_chan.write_toggle)
);

`default_nettype wire
